### hdl/srgm_pkg.sv
package srgm_pkg;

  localparam int ID_WIDTH = 16;
  localparam int CNT_W    = $clog2(ID_WIDTH + 1);
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_REPLICAS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE   = 2'd2;

  // opcodes (high bit set means transpose)
  localparam logic [1:0] OP_LOCATE    = 2'd0;
  localparam logic [1:0] OP_PLACE     = 2'd1;
  localparam logic [1:0] OP_TRANSPOSE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REP_RANGE = 3'd1,
    ST_GRP_RANGE = 3'd2,
    ST_IDX_RANGE = 3'd3,
    ST_NO_TRANS  = 3'd4,
    ST_BAD_CFG   = 3'd5
  } status_t;

  // values derived from the configuration registers
  typedef struct packed {
    logic                bad;
    logic [ID_WIDTH-1:0] n;
    logic [ID_WIDTH-1:0] g;
    logic [ID_WIDTH-1:0] seff;
    logic [ID_WIDTH-1:0] sg;
    logic [ID_WIDTH-1:0] ngroups;
    logic                tbad;
    logic [ID_WIDTH-1:0] ts;
    logic [ID_WIDTH-1:0] tz;
  } cfg_t;

  // per-query context travelling down the pipeline
  typedef struct packed {
    status_t             status;
    logic                is_loc;
    logic                is_place;
    logic [ID_WIDTH-1:0] idx;
    logic [ID_WIDTH-1:0] gcount;
    logic [ID_WIDTH-1:0] ts;
    logic [ID_WIDTH-1:0] tz;
    logic [ID_WIDTH-1:0] q1;
    logic [ID_WIDTH-1:0] r1;
  } ctx_t;

endpackage

### hdl/srgm_cfg.sv
module srgm_cfg import srgm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_WIDTH-1:0]  cfg_data,
  output logic                 busy,
  output cfg_t                 info
);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_MUL  = 4'b0010,
    CS_DIV  = 4'b0100,
    CS_FIN  = 4'b1000
  } cfg_state_t;

  cfg_state_t state;
  logic [ID_WIDTH-1:0]   n, s, g;
  logic [2*ID_WIDTH-1:0] prod;
  logic [ID_WIDTH-1:0]   shn, ra, rb;
  logic [CNT_W-1:0]      cnt;

  logic [ID_WIDTH:0]     trial_a, trial_b, diff_a, diff_b;
  logic                  fit_a, fit_b;
  cfg_t                  info_next;

  // one quotient bit per cycle: n / g and n % (s * g)
  assign trial_a = {ra, shn[ID_WIDTH-1]};
  assign trial_b = {rb, shn[ID_WIDTH-1]};
  assign fit_a   = trial_a >= {1'b0, g};
  assign fit_b   = {{(ID_WIDTH-1){1'b0}}, trial_b} >= prod;
  assign diff_a  = trial_a - {1'b0, g};
  assign diff_b  = trial_b - prod[ID_WIDTH:0];

  always_comb begin
    info_next      = '0;
    info_next.n    = n;
    info_next.g    = g;
    info_next.bad  = (n == '0) || (s == '0) || (g == '0) || (rb != '0);
    info_next.ngroups = shn;
    if (g == ID_WIDTH'(1)) begin
      info_next.seff = ID_WIDTH'(1);
      info_next.sg   = ID_WIDTH'(1);
    end else begin
      info_next.seff = s;
      info_next.sg   = prod[ID_WIDTH-1:0];
    end
    if (info_next.seff == ID_WIDTH'(1)) begin
      info_next.ts = g;
      info_next.tz = shn;
    end else if (prod == {{ID_WIDTH{1'b0}}, n}) begin
      info_next.ts = ID_WIDTH'(1);
      info_next.tz = s;
    end else begin
      info_next.tbad = 1'b1;
    end
    if (!info_next.tbad && info_next.tz == ID_WIDTH'(1)) begin
      info_next.ts = ID_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      n     <= ID_WIDTH'(1);
      s     <= ID_WIDTH'(1);
      g     <= ID_WIDTH'(1);
      info  <= '{bad: 1'b0, tbad: 1'b0, default: ID_WIDTH'(1)};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_REPLICAS: n <= cfg_data;
        REG_GROUP_STRIDE: s <= cfg_data;
        REG_GROUP_SIZE:   g <= cfg_data;
        default: ;
      endcase
      state <= CS_MUL;
    end else begin
      unique case (state)
        CS_IDLE: ;
        CS_MUL: begin
          prod  <= s * g;
          shn   <= n;
          ra    <= '0;
          rb    <= '0;
          cnt   <= '0;
          state <= CS_DIV;
        end
        CS_DIV: begin
          ra  <= fit_a ? diff_a[ID_WIDTH-1:0] : trial_a[ID_WIDTH-1:0];
          rb  <= fit_b ? diff_b[ID_WIDTH-1:0] : trial_b[ID_WIDTH-1:0];
          shn <= {shn[ID_WIDTH-2:0], fit_a};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ID_WIDTH - 1)) begin
            state <= CS_FIN;
          end
        end
        CS_FIN: begin
          info  <= info_next;
          state <= CS_IDLE;
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  assign busy = (state != CS_IDLE);

endmodule

### hdl/srgm_div.sv
module srgm_div import srgm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ID_WIDTH-1:0] in_num,
  input  logic [ID_WIDTH-1:0] in_den,
  input  ctx_t                in_ctx,
  output logic                out_valid,
  output logic [ID_WIDTH-1:0] out_quo,
  output logic [ID_WIDTH-1:0] out_rem,
  output ctx_t                out_ctx
);

  // one restoring step per stage, quotient bits shift in behind the dividend
  logic                vld [1:ID_WIDTH];
  logic [ID_WIDTH-1:0] num [1:ID_WIDTH];
  logic [ID_WIDTH-1:0] rem [1:ID_WIDTH];
  logic [ID_WIDTH-1:0] den [1:ID_WIDTH-1];
  ctx_t                ctx [1:ID_WIDTH];

  for (genvar k = 0; k < ID_WIDTH; k++) begin : g_step
    logic                v_in;
    logic [ID_WIDTH-1:0] n_in, r_in, d_in;
    ctx_t                c_in;
    logic [ID_WIDTH:0]   trial, diff;
    logic                fit;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = in_num;
      assign r_in = '0;
      assign d_in = in_den;
      assign c_in = in_ctx;
    end else begin : g_next
      assign v_in = vld[k];
      assign n_in = num[k];
      assign r_in = rem[k];
      assign d_in = den[k];
      assign c_in = ctx[k];
    end

    assign trial = {r_in, n_in[ID_WIDTH-1]};
    assign diff  = trial - {1'b0, d_in};
    assign fit   = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_in;
      end
      num[k+1] <= {n_in[ID_WIDTH-2:0], fit};
      rem[k+1] <= fit ? diff[ID_WIDTH-1:0] : trial[ID_WIDTH-1:0];
      ctx[k+1] <= c_in;
    end

    if (k < ID_WIDTH - 1) begin : g_den
      always_ff @(posedge clk) begin
        den[k+1] <= d_in;
      end
    end
  end

  assign out_valid = vld[ID_WIDTH];
  assign out_quo   = num[ID_WIDTH];
  assign out_rem   = rem[ID_WIDTH];
  assign out_ctx   = ctx[ID_WIDTH];

endmodule

### hdl/strided_replica_group_mapper_top.sv
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// query in  | start, busy               | opcode, replica_id, group_id, member_index
// config    | cfg_we                    | cfg_index, cfg_data
// result    | done (one-cycle strobe)   | found_*, group_count, transposed_*, status
//
// a query beat is taken when start is high and busy is low, one per cycle
// each result appears after its query beat has passed the front stage, two ID_WIDTH-stage
// divider pipelines, the multiply stage and the output stage
// a config write makes busy high while the bit-serial config divider steps through its
// multiply, divide and finish states and recomputes group count and divisibility
// synchronous reset flushes the pipeline; the receiver cannot stall, so nothing waits
module strided_replica_group_mapper_top import srgm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [ID_WIDTH-1:0]  replica_id,
  input  logic [ID_WIDTH-1:0]  group_id,
  input  logic [ID_WIDTH-1:0]  member_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_WIDTH-1:0]  cfg_data,
  output logic                 done,
  output logic [ID_WIDTH-1:0]  found_group,
  output logic [ID_WIDTH-1:0]  found_index,
  output logic [ID_WIDTH-1:0]  found_replica,
  output logic [ID_WIDTH-1:0]  group_count,
  output logic [ID_WIDTH-1:0]  transposed_stride,
  output logic [ID_WIDTH-1:0]  transposed_size,
  output logic [2:0]           status
);

  cfg_t info;

  srgm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .info      (info)
  );

  // front stage: decode, range checks, transpose and divider operands
  logic                accept;
  logic                is_tr, is_place, is_loc;
  ctx_t                ctx_in;
  logic                s0_valid;
  ctx_t                s0_ctx;
  logic [ID_WIDTH-1:0] s0_num, s0_den;

  assign accept   = start && !busy;
  assign is_tr    = opcode[1];
  assign is_place = (opcode == OP_PLACE);
  assign is_loc   = (opcode == OP_LOCATE);

  always_comb begin
    ctx_in          = '0;
    ctx_in.is_loc   = is_loc;
    ctx_in.is_place = is_place;
    ctx_in.idx      = member_index;
    if (info.bad) begin
      ctx_in.status = ST_BAD_CFG;
    end else begin
      ctx_in.gcount = info.ngroups;
      priority if (is_tr) begin
        if (info.tbad) begin
          ctx_in.status = ST_NO_TRANS;
        end else begin
          ctx_in.status = ST_OK;
          ctx_in.ts     = info.ts;
          ctx_in.tz     = info.tz;
        end
      end else if (is_place) begin
        priority if (group_id >= info.ngroups) ctx_in.status = ST_GRP_RANGE;
        else if (member_index >= info.g)       ctx_in.status = ST_IDX_RANGE;
        else                                   ctx_in.status = ST_OK;
      end else begin
        ctx_in.status = (replica_id >= info.n) ? ST_REP_RANGE : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
    s0_ctx <= ctx_in;
    // locate: replica / (stride * size); place: group / stride
    s0_num <= is_place ? group_id : replica_id;
    s0_den <= is_place ? info.seff : info.sg;
  end

  // first divider: block number and offset, or group split by stride
  logic                d1_valid;
  logic [ID_WIDTH-1:0] d1_quo, d1_rem;
  ctx_t                d1_ctx, d2_ctx_in;

  srgm_div u_div1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .in_num    (s0_num),
    .in_den    (s0_den),
    .in_ctx    (s0_ctx),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_ctx   (d1_ctx)
  );

  always_comb begin
    d2_ctx_in    = d1_ctx;
    d2_ctx_in.q1 = d1_quo;
    d2_ctx_in.r1 = d1_rem;
  end

  // second divider: offset in block / stride gives index and interleave lane
  logic                d2_valid;
  logic [ID_WIDTH-1:0] d2_quo, d2_rem;
  ctx_t                d2_ctx;

  srgm_div u_div2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .in_num    (d1_rem),
    .in_den    (info.seff),
    .in_ctx    (d2_ctx_in),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_ctx   (d2_ctx)
  );

  // multiply stage
  logic                  m_valid;
  ctx_t                  m_ctx;
  logic [ID_WIDTH-1:0]   m_p1, m_p2, m_q2, m_r2;
  logic [2*ID_WIDTH-1:0] prod1, prod2;

  assign prod1 = d2_ctx.q1 * (d2_ctx.is_place ? info.sg : info.seff);
  assign prod2 = d2_ctx.idx * info.seff;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d2_valid;
    end
    m_ctx <= d2_ctx;
    m_p1  <= prod1[ID_WIDTH-1:0];
    m_p2  <= prod2[ID_WIDTH-1:0];
    m_q2  <= d2_quo;
    m_r2  <= d2_rem;
  end

  // output stage: sums and zeroing of unused fields
  logic m_ok;
  assign m_ok = (m_ctx.status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    // group = lane + stride * block; replica = first of group + index * stride
    found_group       <= (m_ok && m_ctx.is_loc) ? m_r2 + m_p1 : '0;
    found_index       <= (m_ok && m_ctx.is_loc) ? m_q2 : '0;
    found_replica     <= (m_ok && m_ctx.is_place) ? m_p1 + m_ctx.r1 + m_p2 : '0;
    group_count       <= m_ctx.gcount;
    transposed_stride <= m_ctx.ts;
    transposed_size   <= m_ctx.tz;
    status            <= m_ctx.status;
  end

endmodule

### hdl/srgm_check.sv
module srgm_check import srgm_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 cfg_we,
  input logic                 done,
  input logic [ID_WIDTH-1:0]  found_group,
  input logic [ID_WIDTH-1:0]  found_index,
  input logic [ID_WIDTH-1:0]  found_replica,
  input logic [ID_WIDTH-1:0]  group_count,
  input logic [ID_WIDTH-1:0]  transposed_stride,
  input logic [ID_WIDTH-1:0]  transposed_size,
  input logic [2:0]           status
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ST_BAD_CFG))
    else $error("undefined status code");

  a_bad_cfg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_BAD_CFG) |-> (found_group == '0 && found_index == '0 &&
      found_replica == '0 && group_count == '0 && transposed_stride == '0 &&
      transposed_size == '0))
    else $error("bad config result carries data");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_REP_RANGE || status == ST_GRP_RANGE ||
      status == ST_IDX_RANGE)) |-> (found_group == '0 && found_index == '0 &&
      found_replica == '0 && transposed_stride == '0 && transposed_size == '0))
    else $error("range error result carries data");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_we))
    else $error("busy raised without a config write");

endmodule

bind strided_replica_group_mapper_top srgm_check u_check (.*);
